// ----- rtl/core/swm_pkg.sv -----
// Shared types and constants of the sliding window median filter.
`default_nettype none

package swm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int RESULT_W = 33;
    localparam int CFG_W    = 7;

    // Flags that one cell hands to its neighbors.
    typedef struct packed {
        logic valid;  // cell holds a live sample
        logic gt;     // cell value is above the incoming sample, or the cell is empty
        logic dpre;   // the departing sample sits in this cell or below it
    } cell_flags_t;

endpackage

`default_nettype wire

// ----- rtl/core/sliding_window_median_top.sv -----
// Top level of the sliding window median filter: cell chain, fill control and output.
//
// Running median over the last window_len signed samples (1 to WINDOW_MAX; zero acts as
// one, larger values saturate). The samples sit sorted in a chain of WINDOW_MAX cells;
// every accepted request inserts the new sample and, once the window is full, drops the
// oldest one in the same update; one sample is taken per clock while sample_stall is low.
// A result, twice the median, goes to the output register once it is free; none is
// given until window_len samples have arrived. Writing window_len restarts the fill.
`default_nettype none

module sliding_window_median_top #(
    parameter int WINDOW_MAX = 64
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 window_len_we,
    input  wire         [swm_pkg::CFG_W-1:0]    window_len,
    input  wire                                 sample_valid,
    output logic                                sample_stall,
    input  wire signed  [swm_pkg::SAMPLE_W-1:0] sample,
    output logic                                median_valid,
    input  wire                                 median_stall,
    output logic signed [swm_pkg::RESULT_W-1:0] median_doubled
);

    localparam int CNT_W     = $clog2(WINDOW_MAX + 1);
    localparam int AGE_W     = $clog2(WINDOW_MAX);
    localparam int RESET_EFF = (WINDOW_MAX < 3) ? WINDOW_MAX : 3;

    logic [CNT_W-1:0] eff_reg, eff_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             pend_reg, pend_next;
    logic             out_valid_reg;
    logic signed [swm_pkg::RESULT_W-1:0] out_data_reg, out_data_next;

    logic             accept, load, full, produce;
    logic [AGE_W-1:0] last_age, lo_idx, hi_idx;
    logic signed [swm_pkg::SAMPLE_W-1:0] lo_sel, hi_sel;

    swm_pkg::cell_flags_t                flags_w [WINDOW_MAX];
    logic signed [swm_pkg::SAMPLE_W-1:0] value_w [WINDOW_MAX];
    logic        [AGE_W-1:0]             age_w   [WINDOW_MAX];
    logic signed [swm_pkg::SAMPLE_W-1:0] lo_tap_w [WINDOW_MAX];
    logic signed [swm_pkg::SAMPLE_W-1:0] hi_tap_w [WINDOW_MAX];
    logic        [WINDOW_MAX-1:0]        valid_vec;

    localparam swm_pkg::cell_flags_t BOTTOM_FLAGS = '{valid: 1'b1, gt: 1'b0, dpre: 1'b0};
    localparam swm_pkg::cell_flags_t TOP_FLAGS    = '{valid: 1'b0, gt: 1'b1, dpre: 1'b0};

    // A pending result must move to the output register before the cells change again.
    assign load         = pend_reg && (!out_valid_reg || !median_stall);
    assign sample_stall = pend_reg && !load;
    assign accept       = sample_valid && !sample_stall;
    assign median_valid = out_valid_reg;
    assign median_doubled = out_data_reg;

    assign full     = (fill_reg >= eff_reg);
    assign produce  = (fill_reg >= eff_reg - 1'b1);
    assign last_age = AGE_W'(eff_reg - 1'b1);
    assign hi_idx   = AGE_W'(eff_reg >> 1);
    assign lo_idx   = eff_reg[0] ? hi_idx : hi_idx - 1'b1;

    generate
        for (genvar i = 0; i < WINDOW_MAX; i++)
        begin : g_cell
            swm_cell #(
                .AGE_W (AGE_W),
                .IDX   (i)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .step       (accept),
                .clear      (window_len_we),
                .full       (full),
                .last_age   (last_age),
                .lo_idx     (lo_idx),
                .hi_idx     (hi_idx),
                .sample     (sample),
                .prev_flags ((i == 0) ? BOTTOM_FLAGS : flags_w[(i == 0) ? 0 : i - 1]),
                .prev_value ((i == 0) ? sample : value_w[(i == 0) ? 0 : i - 1]),
                .prev_age   ((i == 0) ? '0 : age_w[(i == 0) ? 0 : i - 1]),
                .next_flags ((i == WINDOW_MAX - 1) ? TOP_FLAGS
                                                   : flags_w[(i == WINDOW_MAX - 1) ? i : i + 1]),
                .next_value ((i == WINDOW_MAX - 1) ? sample
                                                   : value_w[(i == WINDOW_MAX - 1) ? i : i + 1]),
                .next_age   ((i == WINDOW_MAX - 1) ? '0
                                                   : age_w[(i == WINDOW_MAX - 1) ? i : i + 1]),
                .flags      (flags_w[i]),
                .value      (value_w[i]),
                .age        (age_w[i]),
                .lo_tap     (lo_tap_w[i]),
                .hi_tap     (hi_tap_w[i])
            );
            assign valid_vec[i] = flags_w[i].valid;
        end
    endgenerate

    always_comb
    begin
        lo_sel = '0;
        hi_sel = '0;
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            lo_sel = lo_sel | lo_tap_w[i];
            hi_sel = hi_sel | hi_tap_w[i];
        end
        out_data_next = swm_pkg::RESULT_W'(lo_sel) + swm_pkg::RESULT_W'(hi_sel);
    end

    always_comb
    begin
        eff_next  = eff_reg;
        fill_next = fill_reg;
        pend_next = pend_reg && !load;
        if (window_len_we)
        begin
            if (window_len == '0)
            begin
                eff_next = CNT_W'(1);
            end
            else if (32'(window_len) > 32'(WINDOW_MAX))
            begin
                eff_next = CNT_W'(WINDOW_MAX);
            end
            else
            begin
                eff_next = CNT_W'(window_len);
            end
            fill_next = '0;
        end
        else if (accept)
        begin
            if (!full)
            begin
                fill_next = fill_reg + 1'b1;
            end
            pend_next = produce;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_reg       <= CNT_W'(RESET_EFF);
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            eff_reg  <= eff_next;
            fill_reg <= fill_next;
            pend_reg <= pend_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!median_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // The number of live cells always matches the fill count.
    a_fill_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(fill_reg))
        else $error("live cell count differs from fill count");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= eff_reg)
        else $error("fill count above window length");

    // A new request is never taken while its predecessor's result is still unloaded.
    a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg && accept |-> load)
        else $error("pending result overwritten by a new request");

endmodule

`default_nettype wire

// ----- rtl/core/swm_cell.sv -----
// One cell of the sorted chain: holds one sample and its age.
`default_nettype none

module swm_cell #(
    parameter int AGE_W = 6,
    parameter int IDX   = 0
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 step,
    input  wire                                 clear,
    input  wire                                 full,
    input  wire         [AGE_W-1:0]             last_age,
    input  wire         [AGE_W-1:0]             lo_idx,
    input  wire         [AGE_W-1:0]             hi_idx,
    input  wire signed  [swm_pkg::SAMPLE_W-1:0] sample,
    input  wire swm_pkg::cell_flags_t           prev_flags,
    input  wire signed  [swm_pkg::SAMPLE_W-1:0] prev_value,
    input  wire         [AGE_W-1:0]             prev_age,
    input  wire swm_pkg::cell_flags_t           next_flags,
    input  wire signed  [swm_pkg::SAMPLE_W-1:0] next_value,
    input  wire         [AGE_W-1:0]             next_age,
    output swm_pkg::cell_flags_t                flags,
    output logic signed [swm_pkg::SAMPLE_W-1:0] value,
    output logic        [AGE_W-1:0]             age,
    output logic signed [swm_pkg::SAMPLE_W-1:0] lo_tap,
    output logic signed [swm_pkg::SAMPLE_W-1:0] hi_tap
);

    logic signed [swm_pkg::SAMPLE_W-1:0] value_reg, value_next;
    logic        [AGE_W-1:0]             age_reg, age_next;
    logic                                valid_reg, valid_next;

    logic                                gt_own, del_own, d_own;
    logic signed [swm_pkg::SAMPLE_W-1:0] u_here_value, u_below_value;
    logic        [AGE_W-1:0]             u_here_age, u_below_age;
    logic                                u_here_valid, u_below_valid;
    logic                                u_here_gt, u_below_gt;

    always_comb
    begin
        gt_own  = !valid_reg || (value_reg > sample);
        del_own = full && valid_reg && (age_reg == last_age);
        d_own   = prev_flags.dpre || del_own;

        // The chain with the departing sample taken out, seen at this cell.
        u_here_value = d_own ? next_value       : value_reg;
        u_here_age   = d_own ? next_age         : age_reg;
        u_here_valid = d_own ? next_flags.valid : valid_reg;
        u_here_gt    = d_own ? next_flags.gt    : gt_own;

        // The same chain seen at the cell below.
        u_below_value = prev_flags.dpre ? value_reg : prev_value;
        u_below_age   = prev_flags.dpre ? age_reg   : prev_age;
        u_below_valid = prev_flags.dpre ? valid_reg : prev_flags.valid;
        u_below_gt    = prev_flags.dpre ? gt_own    : prev_flags.gt;

        // Larger values shift up by one to make room for the new sample.
        if (u_below_gt)
        begin
            value_next = u_below_value;
            age_next   = u_below_age + 1'b1;
            valid_next = u_below_valid;
        end
        else if (u_here_gt)
        begin
            value_next = sample;
            age_next   = '0;
            valid_next = 1'b1;
        end
        else
        begin
            value_next = u_here_value;
            age_next   = u_here_age + 1'b1;
            valid_next = u_here_valid;
        end

        flags.valid = valid_reg;
        flags.gt    = gt_own;
        flags.dpre  = d_own;
        value       = value_reg;
        age         = age_reg;
        lo_tap      = (lo_idx == AGE_W'(IDX)) ? value_reg : '0;
        hi_tap      = (hi_idx == AGE_W'(IDX)) ? value_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (step)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the sliding window median filter.
`timescale 1ns / 1ps

module testbench;

    localparam int WINDOW_MAX     = 64;
    localparam int TARGET_SAMPLES = 1700;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 250;

    localparam logic signed [swm_pkg::SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;
    localparam logic signed [swm_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;

    logic                                clk            = 1'b0;
    logic                                rst_n          = 1'b0;
    logic                                window_len_we  = 1'b0;
    logic [swm_pkg::CFG_W-1:0]           window_len     = '0;
    logic                                sample_valid   = 1'b0;
    logic signed [swm_pkg::SAMPLE_W-1:0] sample         = '0;
    logic                                median_stall   = 1'b0;
    logic                                sample_stall;
    logic                                median_valid;
    logic signed [swm_pkg::RESULT_W-1:0] median_doubled;

    // Shared control between the test sequence and the result side.
    logic calm       = 1'b0;
    int   hold_token = 0;
    int   hold_seen  = 0;
    int   hold_left  = 0;

    int errors          = 0;
    int samples_sent    = 0;
    int medians_checked = 0;
    int window_writes   = 0;

    // Shadow copy of the filter state.
    logic [swm_pkg::CFG_W-1:0]           window_reg;
    logic signed [swm_pkg::SAMPLE_W-1:0] history_vals [WINDOW_MAX];
    logic signed [swm_pkg::SAMPLE_W-1:0] sorted_vals  [WINDOW_MAX];
    int                                  fill_cnt;
    int                                  oldest_slot;

    logic signed [swm_pkg::RESULT_W-1:0] pending_medians [$];

    sliding_window_median_top #(
        .WINDOW_MAX(WINDOW_MAX)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .window_len_we (window_len_we),
        .window_len    (window_len),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .sample        (sample),
        .median_valid  (median_valid),
        .median_stall  (median_stall),
        .median_doubled(median_doubled)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Median predictor
    // ------------------------------------------------------------------

    function automatic int window_span();
        if (window_reg == 0)
            return 1;
        if (window_reg > WINDOW_MAX)
            return WINDOW_MAX;
        return int'(window_reg);
    endfunction

    function automatic void sorted_insert(input logic signed [swm_pkg::SAMPLE_W-1:0] v,
                                          input int count);
        int p;
        p = 0;
        while (p < count && sorted_vals[p] <= v)
            p++;
        for (int i = count; i > p; i--)
            sorted_vals[i] = sorted_vals[i-1];
        sorted_vals[p] = v;
    endfunction

    // Takes one sample into the shadow state and tells whether a median comes out.
    function automatic void median_accept(input logic signed [swm_pkg::SAMPLE_W-1:0] v,
                                          output bit emitted,
                                          output logic signed [swm_pkg::RESULT_W-1:0] med);
        int                                  w;
        int                                  pos;
        int                                  p;
        logic signed [swm_pkg::SAMPLE_W-1:0] gone;
        logic signed [swm_pkg::SAMPLE_W-1:0] lo;
        logic signed [swm_pkg::SAMPLE_W-1:0] hi;
        w = window_span();
        pos = (oldest_slot >= w) ? 0 : oldest_slot;
        if (fill_cnt < w)
        begin
            sorted_insert(v, fill_cnt);
            fill_cnt++;
        end
        else
        begin
            // Only one copy of a repeated value leaves the sorted store.
            gone = history_vals[pos];
            p = 0;
            while (p < w && sorted_vals[p] != gone)
                p++;
            for (int i = p; i < w - 1; i++)
                sorted_vals[i] = sorted_vals[i+1];
            sorted_insert(v, w - 1);
        end
        history_vals[pos] = v;
        oldest_slot = (pos + 1 >= w) ? 0 : pos + 1;
        emitted = (fill_cnt >= w);
        if (w % 2 == 1)
        begin
            lo = sorted_vals[w/2];
            hi = sorted_vals[w/2];
        end
        else
        begin
            lo = sorted_vals[w/2 - 1];
            hi = sorted_vals[w/2];
        end
        med = $signed({lo[swm_pkg::SAMPLE_W-1], lo}) + $signed({hi[swm_pkg::SAMPLE_W-1], hi});
    endfunction

    function automatic logic signed [swm_pkg::SAMPLE_W-1:0] pick_sample();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode == 0)
        begin
            case ($urandom_range(0, 3))
                0: return SAMPLE_MIN;
                1: return SAMPLE_MAX;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        // Narrow values give many equal samples in the window.
        if (mode < 4)
            return $signed($urandom_range(0, 8)) - 32'sd4;
        return $urandom;
    endfunction

    // ------------------------------------------------------------------
    // Result side: stall generation and checking
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            median_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            median_stall <= 1'b1;
        end
        else if (calm)
            median_stall <= 1'b0;
        else
            median_stall <= ($urandom_range(0, 99) < 32);
    end

    always @(posedge clk)
    begin : check_medians
        logic signed [swm_pkg::RESULT_W-1:0] want_med;
        if (rst_n && median_valid && !median_stall)
        begin
            medians_checked++;
            if (pending_medians.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected median, expected none, actual %0d",
                         $time, median_doubled);
            end
            else
            begin
                want_med = pending_medians.pop_front();
                if (median_doubled !== want_med)
                begin
                    errors++;
                    $display("%0t: median_doubled mismatch, expected %0d, actual %0d",
                             $time, want_med, median_doubled);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared driving tasks
    // ------------------------------------------------------------------

    task automatic send_sample(input logic signed [swm_pkg::SAMPLE_W-1:0] v);
        bit                                  emitted;
        logic signed [swm_pkg::RESULT_W-1:0] med;
        sample_valid <= 1'b1;
        sample <= v;
        do
            @(posedge clk);
        while (sample_stall);
        median_accept(v, emitted, med);
        if (emitted)
            pending_medians = {pending_medians, med};
        samples_sent++;
        if (!calm)
        begin
            while ($urandom_range(0, 99) < 32)
            begin
                sample_valid <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_sample(pick_sample());
    endtask

    // Ends a phase: lets every median come out and the pipeline settle.
    task automatic drain();
        sample_valid <= 1'b0;
        while (pending_medians.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_window(input logic [swm_pkg::CFG_W-1:0] v);
        window_len_we <= 1'b1;
        window_len <= v;
        @(posedge clk);
        window_reg = v;
        fill_cnt = 0;
        oldest_slot = 0;
        window_writes++;
        window_len_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_reset_window();
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(32'sd0);
        send_sample(-32'sd1);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        drain();
    endtask

    // Zero acts as a window of one sample.
    task automatic test_single_window();
        set_window(7'd0);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(-32'sd1);
        drain();
        set_window(7'd1);
        send_sample(32'sd0);
        send_sample(32'sd1);
        drain();
    endtask

    // Even window: the result is the sum of the two middle samples.
    task automatic test_even_window();
        set_window(7'd2);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        send_sample(-32'sd1);
        send_sample(32'sd0);
        send_sample(32'sd5);
        send_sample(32'sd5);
        drain();
    endtask

    // A second write in the middle of a fill starts the count again.
    task automatic test_refill();
        set_window(7'd4);
        send_random(2);
        drain();
        set_window(7'd4);
        send_random(9);
        drain();
    endtask

    task automatic test_long_windows();
        set_window(7'd64);
        send_random(90);
        drain();
        set_window(7'd127);
        send_random(80);
        drain();
        set_window(7'd65);
        send_random(70);
        drain();
    endtask

    // The result side holds off long enough for the filter to stall its input.
    task automatic test_backpressure();
        set_window(7'd4);
        hold_token <= hold_token + 1;
        send_random(60);
        drain();
    endtask

    task automatic test_steady_stream();
        set_window(7'd7);
        calm <= 1'b1;
        send_random(250);
        calm <= 1'b0;
        drain();
    endtask

    task automatic test_random_windows();
        logic [swm_pkg::CFG_W-1:0] w;
        int                        k;
        while (samples_sent < TARGET_SAMPLES)
        begin
            k = $urandom_range(0, 9);
            if (k < 7)
                w = swm_pkg::CFG_W'($urandom_range(1, 9));
            else if (k < 9)
                w = swm_pkg::CFG_W'($urandom_range(10, 64));
            else
                w = swm_pkg::CFG_W'($urandom_range(0, 127));
            set_window(w);
            send_random(window_span() + int'($urandom_range(4, 60)));
            drain();
        end
    endtask

    initial
    begin
        window_reg = 7'd3;
        fill_cnt = 0;
        oldest_slot = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_window();
        test_single_window();
        test_even_window();
        test_refill();
        test_long_windows();
        test_backpressure();
        test_steady_stream();
        test_random_windows();

        errors += pending_medians.size();
        $display("summary: %0d samples sent, %0d medians checked, %0d window settings",
                 samples_sent, medians_checked, window_writes);
        $display("summary: windows 0 to 127, extremes, repeats, long output hold-off");
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
